// File: hw/rtl/c3e_pkg.sv
`default_nettype none

package c3e_pkg;

    // Input transfer: one RGB pixel or a drain marker
    typedef struct packed {
        logic [7:0] chan_zero;
        logic [7:0] chan_one;
        logic [7:0] chan_two;
        logic       drain;
    } pix_t;

    // Output transfer: one filtered pixel
    typedef struct packed {
        logic [7:0] out_zero;
        logic [7:0] out_one;
        logic [7:0] out_two;
        logic       frame_last;
    } res_t;

    // Selected 3x3 neighborhood handed from the window to the lanes
    typedef struct packed {
        logic             res;
        logic             corner;
        logic             last;
        logic [23:0]      center;
        logic [8:0][23:0] px;
    } tap_bus_t;

    // Register map (byte address = 8 * index)
    localparam int unsigned ADDR_W = 6;
    localparam logic [2:0] REG_W_TOP  = 3'd0;
    localparam logic [2:0] REG_W_MID  = 3'd1;
    localparam logic [2:0] REG_W_BOT  = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    // Height limits after saturation
    localparam logic [15:0] H_MIN = 16'd3;
    localparam logic [15:0] H_MAX = 16'd65534;

    // Clamp limit of the Q.8 sum (255.0)
    localparam logic signed [29:0] SUM_HI = 30'sd65280;
    localparam logic [7:0] PIX_MAX = 8'd255;
    localparam logic [7:0] PIX_MIN = 8'd0;

endpackage

`default_nettype wire

// File: hw/rtl/conv3x3_rgb_edge_replicate.sv
// Throughput: one pixel or drain transfer per cycle when not stalled; one line-store read and one
//   write per accepted transfer. Result path: a pixel's result leaves width+1 transfers after
//   it through line-store read, window select, multiply and row-sum stages to the output register.
// Reset: counters, window, valids and registers return to defaults; the line stores are not
//   cleared and need no clearing pass.
`default_nettype none

module conv3x3_rgb_edge_replicate #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pix_valid,
    output logic                                pix_ready,
    input  wire c3e_pkg::pix_t                  pix,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output c3e_pkg::res_t                       res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [c3e_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [63:0]                    pwdata,
    output logic      [63:0]                    prdata,
    output logic                                pready
);

    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

    logic [47:0] w_top_reg, w_mid_reg, w_bot_reg;
    logic [16:0] offset_reg;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic          adv;
    logic          acc;

    c3e_pkg::tap_bus_t taps;
    logic [8:0][15:0]  wt;
    logic [2:0][7:0]   lane_val;

    logic        p_res_reg, s_res_reg;
    logic        p_corner_reg, s_corner_reg, p_last_reg, s_last_reg;
    logic [23:0] p_center_reg, s_center_reg;
    logic        res_valid_reg;
    c3e_pkg::res_t res_reg, res_next;

    // Register writes and reads
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_top_reg  <= 48'd0;
            w_mid_reg  <= 48'd256;
            w_bot_reg  <= 48'd0;
            offset_reg <= 17'd0;
            width_reg  <= 11'd640;
            height_reg <= 16'd480;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                c3e_pkg::REG_W_TOP:  w_top_reg  <= pwdata[47:0];
                c3e_pkg::REG_W_MID:  w_mid_reg  <= pwdata[47:0];
                c3e_pkg::REG_W_BOT:  w_bot_reg  <= pwdata[47:0];
                c3e_pkg::REG_OFFSET: offset_reg <= pwdata[16:0];
                c3e_pkg::REG_WIDTH:  width_reg  <= pwdata[10:0];
                c3e_pkg::REG_HEIGHT: height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            c3e_pkg::REG_W_TOP:  prdata = {16'd0, w_top_reg};
            c3e_pkg::REG_W_MID:  prdata = {16'd0, w_mid_reg};
            c3e_pkg::REG_W_BOT:  prdata = {16'd0, w_bot_reg};
            c3e_pkg::REG_OFFSET: prdata = {47'd0, offset_reg};
            c3e_pkg::REG_WIDTH:  prdata = {53'd0, width_reg};
            c3e_pkg::REG_HEIGHT: prdata = {48'd0, height_reg};
            default:             prdata = 64'd0;
        endcase
    end

    // Saturate frame size to the supported range
    always_comb
    begin
        if (32'(width_reg) < 32'd3)
        begin
            w_eff = WW'(3);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg < c3e_pkg::H_MIN)
        begin
            h_eff = c3e_pkg::H_MIN;
        end
        else if (height_reg > c3e_pkg::H_MAX)
        begin
            h_eff = c3e_pkg::H_MAX;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // Hold the pipe only when a finished result would overwrite a waiting one
    assign adv       = !res_valid_reg || res_ready || !s_res_reg;
    assign pix_ready = adv;
    assign acc       = pix_valid && adv;

    c3e_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .acc   (acc),
        .pix   (pix),
        .w_eff (w_eff),
        .h_eff (h_eff),
        .taps  (taps)
    );

    // Unpack weights, left to right within each row
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            wt[j]     = w_top_reg[47-16*j -: 16];
            wt[3 + j] = w_mid_reg[47-16*j -: 16];
            wt[6 + j] = w_bot_reg[47-16*j -: 16];
        end
    end

    // One lane per color channel
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        logic [8:0][7:0] px_ch;

        always_comb
        begin
            for (int k = 0; k < 9; k++)
            begin
                px_ch[k] = taps.px[k][8*ch +: 8];
            end
        end

        c3e_lane u_lane (
            .clk    (clk),
            .en     (adv),
            .px     (px_ch),
            .wt     (wt),
            .offset (offset_reg),
            .value  (lane_val[ch])
        );
    end

    // Carry flags alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_res_reg <= 1'b0;
            s_res_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_res_reg <= taps.res;
            s_res_reg <= p_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_corner_reg <= taps.corner;
            p_last_reg   <= taps.last;
            p_center_reg <= taps.center;
            s_corner_reg <= p_corner_reg;
            s_last_reg   <= p_last_reg;
            s_center_reg <= p_center_reg;
        end
    end

    // Merge lanes; corners pass through unfiltered
    always_comb
    begin
        if (s_corner_reg)
        begin
            res_next.out_zero = s_center_reg[7:0];
            res_next.out_one  = s_center_reg[15:8];
            res_next.out_two  = s_center_reg[23:16];
        end
        else
        begin
            res_next.out_zero = lane_val[0];
            res_next.out_one  = lane_val[1];
            res_next.out_two  = lane_val[2];
        end
        res_next.frame_last = s_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv && s_res_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_res_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> pix_ready)
        else $error("input stalled with empty output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready && s_res_reg) |-> !pix_ready)
        else $error("pending result would be overwritten");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("waiting result changed");

endmodule

`default_nettype wire

// File: hw/rtl/c3e_lane.sv
`default_nettype none

module c3e_lane (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [8:0][7:0]  px,
    input  wire logic [8:0][15:0] wt,
    input  wire logic [16:0]      offset,
    output logic      [7:0]       value
);

    logic signed [24:0] prod_reg  [9];
    logic signed [24:0] prod_next [9];
    logic signed [27:0] rsum_reg  [3];
    logic signed [27:0] rsum_next [3];
    logic signed [29:0] total;

    // Multiply each tap by its weight
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_next[k] = $signed(wt[k]) * $signed({1'b0, px[k]});
        end
    end

    // Sum each kernel row, fold the offset into the top row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum_next[i] = prod_reg[3*i] + prod_reg[3*i+1] + prod_reg[3*i+2];
        end
        rsum_next[0] = rsum_next[0] + $signed(offset);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            rsum_reg <= rsum_next;
        end
    end

    // Add rows, clamp to 0..255 and drop the fraction
    always_comb
    begin
        total = rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
        if (total <= 30'sd0)
        begin
            value = c3e_pkg::PIX_MIN;
        end
        else if (total >= c3e_pkg::SUM_HI)
        begin
            value = c3e_pkg::PIX_MAX;
        end
        else
        begin
            value = total[15:8];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/c3e_window.sv
`default_nettype none

module c3e_window #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               acc,
    input  wire c3e_pkg::pix_t                      pix,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
    input  wire logic [15:0]                        h_eff,
    output c3e_pkg::tap_bus_t                       taps
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW = WW + 1;

    // Line store: {older row, newer row} per column
    logic [47:0] mem [MAX_WIDTH];
    logic [47:0] ram_q_reg;
    logic [47:0] fwd_reg;
    logic        hz_reg;

    logic [AW-1:0] ix_reg, ix_next;
    logic [15:0]   iy_reg, iy_next;
    logic [AW:0]   ix_inc;

    logic          b_valid_reg;
    logic [AW-1:0] b_ix_reg;
    logic [15:0]   b_iy_reg;
    logic [23:0]   b_data_reg;

    logic [23:0] c1_reg [3];
    logic [23:0] c2_reg [3];
    logic [23:0] ncol   [3];
    logic [23:0] col_l  [3];
    logic [23:0] col_r  [3];

    c3e_pkg::tap_bus_t taps_reg, taps_next;
    logic              res_flag_reg;

    logic        wr;
    logic [47:0] q;
    logic [47:0] wr_data;
    logic [23:0] in_data;
    logic        emit_edge, emit_mid;
    logic [15:0] cr;
    logic        c_first, c_last, r_first, r_last;
    logic [1:0]  rs_top, rs_bot;

    assign in_data = pix.drain ? 24'd0 : {pix.chan_two, pix.chan_one, pix.chan_zero};

    // Advance column and row counters, restart after the flush row
    always_comb
    begin
        ix_inc = {1'b0, ix_reg} + 1'b1;
        ix_next = ix_reg;
        iy_next = iy_reg;
        if (ix_reg == '0 && {1'b0, iy_reg} >= {1'b0, h_eff} + 17'd1)
        begin
            ix_next = '0;
            iy_next = '0;
        end
        else if (CW'(ix_inc) >= CW'(w_eff))
        begin
            ix_next = '0;
            iy_next = iy_reg + 16'd1;
        end
        else
        begin
            ix_next = ix_inc[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg      <= '0;
            iy_reg      <= '0;
            b_valid_reg <= 1'b0;
            hz_reg      <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= acc;
            if (acc)
            begin
                ix_reg <= ix_next;
                iy_reg <= iy_next;
                hz_reg <= b_valid_reg && (b_ix_reg == ix_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && acc)
        begin
            b_ix_reg   <= ix_reg;
            b_iy_reg   <= iy_reg;
            b_data_reg <= in_data;
        end
    end

    // Read at acceptance; the accepted transfer is held in the b_ registers and written back from there
    assign wr      = en && b_valid_reg;
    assign q       = hz_reg ? fwd_reg : ram_q_reg;
    assign wr_data = {q[23:0], b_data_reg};

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[b_ix_reg] <= wr_data;
            fwd_reg       <= wr_data;
        end
        if (en && acc)
        begin
            ram_q_reg <= mem[ix_reg];
        end
    end

    // Shift the window by one column
    assign ncol[0] = q[47:24];
    assign ncol[1] = q[23:0];
    assign ncol[2] = b_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                c1_reg[r] <= '0;
                c2_reg[r] <= '0;
            end
        end
        else if (wr)
        begin
            for (int r = 0; r < 3; r++)
            begin
                c1_reg[r] <= c2_reg[r];
                c2_reg[r] <= ncol[r];
            end
        end
    end

    // Pick the output position and replicate missing rows and columns
    always_comb
    begin
        emit_edge = (b_ix_reg == '0) && (b_iy_reg >= 16'd2) && ((b_iy_reg - 16'd2) < h_eff);
        emit_mid  = (b_ix_reg != '0) && (b_iy_reg != 16'd0) && ((b_iy_reg - 16'd1) < h_eff)
                    && (CW'(b_ix_reg) <= CW'(w_eff));
        cr      = emit_edge ? (b_iy_reg - 16'd2) : (b_iy_reg - 16'd1);
        c_first = !emit_edge && (b_ix_reg == AW'(1));
        c_last  = emit_edge || (CW'(b_ix_reg) == CW'(w_eff));
        r_first = (cr == 16'd0);
        r_last  = (cr == h_eff - 16'd1);
        rs_top  = r_first ? 2'd1 : 2'd0;
        rs_bot  = r_last ? 2'd1 : 2'd2;
        for (int r = 0; r < 3; r++)
        begin
            col_l[r] = c_first ? c2_reg[r] : c1_reg[r];
            col_r[r] = c_last ? c2_reg[r] : ncol[r];
        end
        taps_next.res    = b_valid_reg && (emit_edge || emit_mid);
        taps_next.corner = (r_first || r_last) && (c_first || c_last);
        taps_next.last   = r_last && c_last;
        taps_next.center = c2_reg[1];
        taps_next.px[0]  = col_l[rs_top];
        taps_next.px[1]  = c2_reg[rs_top];
        taps_next.px[2]  = col_r[rs_top];
        taps_next.px[3]  = col_l[1];
        taps_next.px[4]  = c2_reg[1];
        taps_next.px[5]  = col_r[1];
        taps_next.px[6]  = col_l[rs_bot];
        taps_next.px[7]  = c2_reg[rs_bot];
        taps_next.px[8]  = col_r[rs_bot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_flag_reg <= 1'b0;
        end
        else if (en)
        begin
            res_flag_reg <= taps_next.res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            taps_reg <= taps_next;
        end
    end

    // Take the result flag from the reset register
    always_comb
    begin
        taps     = taps_reg;
        taps.res = res_flag_reg;
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the filtered pixel stream and holds the results still to arrive
    class conv_scoreboard;
        logic [47:0] kernel_row [3];
        logic [16:0] offset_q8;
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        logic [23:0] line_older [1024];
        logic [23:0] line_newer [1024];
        logic [23:0] win [3][3];
        int unsigned col;
        int unsigned row;
        c3e_pkg::res_t pending_px [$];
        int          errors;
        int          mismatches;
        int          pixels_taken;
        int          results_seen;
        int          frames_done;

        function new();
            kernel_row[0] = '0;
            kernel_row[1] = 48'd256;
            kernel_row[2] = '0;
            offset_q8 = '0;
            width_reg = 11'd640;
            height_reg = 16'd480;
            foreach (line_older[i]) line_older[i] = '0;
            foreach (line_newer[i]) line_newer[i] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            col = 0;
            row = 0;
            errors = 0;
            mismatches = 0;
            pixels_taken = 0;
            results_seen = 0;
            frames_done = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                c3e_pkg::REG_W_TOP:  kernel_row[0] = val[47:0];
                c3e_pkg::REG_W_MID:  kernel_row[1] = val[47:0];
                c3e_pkg::REG_W_BOT:  kernel_row[2] = val[47:0];
                c3e_pkg::REG_OFFSET: offset_q8 = val[16:0];
                c3e_pkg::REG_WIDTH:  width_reg = val[10:0];
                c3e_pkg::REG_HEIGHT: height_reg = val[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg < 3) return 3;
            if (width_reg > 1024) return 1024;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < 3) return 3;
            if (height_reg > 16'd65534) return 65534;
            return height_reg;
        endfunction

        // Weighted sum of one channel, clamped to 0..255 and truncated
        function logic [7:0] filter_chan(int rs[3], int cs[3], int ch);
            longint sum;
            logic signed [15:0] wt;
            logic [7:0] p;
            sum = longint'($signed(offset_q8));
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    wt = kernel_row[i][47 - 16 * j -: 16];
                    p = win[rs[i]][cs[j]][8 * ch +: 8];
                    sum += longint'(wt) * longint'(p);
                end
            if (sum <= 0) return c3e_pkg::PIX_MIN;
            if (sum >= 65280) return c3e_pkg::PIX_MAX;
            return sum[15:8];
        endfunction

        // Form the result centered at (cr, cc), window column ccol
        function void push_result(int unsigned cr, int unsigned cc, int ccol,
                                  int unsigned w, int unsigned h);
            int rs[3];
            int cs[3];
            logic [23:0] px;
            c3e_pkg::res_t r;
            if ((cr == 0 || cr == h - 1) && (cc == 0 || cc == w - 1))
            begin
                px = win[1][ccol];
            end
            else
            begin
                rs[0] = (cr == 0) ? 1 : 0;
                rs[1] = 1;
                rs[2] = (cr == h - 1) ? 1 : 2;
                cs[0] = (cc == 0) ? ccol : ccol - 1;
                cs[1] = ccol;
                cs[2] = (cc == w - 1) ? ccol : ccol + 1;
                for (int ch = 0; ch < 3; ch++)
                    px[8 * ch +: 8] = filter_chan(rs, cs, ch);
            end
            r.out_zero = px[7:0];
            r.out_one = px[15:8];
            r.out_two = px[23:16];
            r.frame_last = (cr == h - 1 && cc == w - 1);
            pending_px.push_back(r);
        endfunction

        // Advance the window by one accepted transfer
        function void note_pixel(c3e_pkg::pix_t p);
            int unsigned w;
            int unsigned h;
            int unsigned ix;
            int unsigned iy;
            logic [23:0] data;
            logic [23:0] up;
            logic [23:0] mid;
            w = eff_width();
            h = eff_height();
            ix = col;
            iy = row;
            data = p.drain ? 24'd0 : {p.chan_two, p.chan_one, p.chan_zero};
            pixels_taken++;
            if (ix == 0 && iy >= 2 && iy - 2 < h)
                push_result(iy - 2, w - 1, 2, w, h);
            up = line_older[ix];
            mid = line_newer[ix];
            line_older[ix] = mid;
            line_newer[ix] = data;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = data;
            if (ix >= 1 && iy >= 1 && iy - 1 < h && ix - 1 < w)
                push_result(iy - 1, ix - 1, 1, w, h);
            if (ix == 0 && iy >= h + 1)
            begin
                col = 0;
                row = 0;
                frames_done++;
            end
            else
            begin
                ix++;
                if (ix >= w)
                begin
                    ix = 0;
                    iy = (iy + 1) & 32'hFFFF;
                end
                col = ix;
                row = iy;
            end
        endfunction

        function void check_result(c3e_pkg::res_t got);
            c3e_pkg::res_t want;
            results_seen++;
            if (pending_px.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result %h", $realtime, got);
                return;
            end
            want = pending_px.pop_front();
            if (got.out_zero !== want.out_zero || got.out_one !== want.out_one ||
                got.out_two !== want.out_two || got.frame_last !== want.frame_last)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d: expected %h/%h/%h last %b, got %h/%h/%h last %b",
                             $realtime, results_seen, want.out_zero, want.out_one,
                             want.out_two, want.frame_last, got.out_zero, got.out_one,
                             got.out_two, got.frame_last);
            end
        endfunction

        function int outstanding();
            return pending_px.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        pix_valid;
    logic                        pix_ready;
    c3e_pkg::pix_t               pix;
    logic                        res_valid;
    logic                        res_ready;
    c3e_pkg::res_t               res;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [c3e_pkg::ADDR_W-1:0]  paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;

    conv_scoreboard sb;
    int burst_left;
    int items_sent;
    int stall_mode;
    int stall_cycle;

    conv3x3_rgb_edge_replicate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Stall the result side on a pattern that is redrawn at random from four modes
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 128 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 9) < 7);
            2: res_ready <= (stall_cycle % 5 != 0);
            default: res_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Send one transfer; hold lowers valid after it
    task automatic send_pix(input c3e_pkg::pix_t p, input bit hold);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        pix_valid <= 1'b1;
        pix <= p;
        do @(posedge clk); while (!pix_ready);
        sb.note_pixel(p);
        items_sent++;
        burst_left--;
        if (hold)
            burst_left = 0;
        if (burst_left == 0)
            pix_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [47:0] rand_kernel_row(bit wild);
        logic [47:0] v;
        if (wild)
            return 48'({$urandom, $urandom});
        for (int j = 0; j < 3; j++)
            v[16 * j +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
        return v;
    endfunction

    // Stream one frame at the current size, then the flush transfers
    task automatic run_frame(input int black_pct, input int noise_pct);
        c3e_pkg::pix_t p;
        int unsigned w;
        int unsigned h;
        w = sb.eff_width();
        h = sb.eff_height();
        for (int i = 0; i < w * h; i++)
        begin
            p.chan_zero = rand_chan();
            p.chan_one = rand_chan();
            p.chan_two = rand_chan();
            p.drain = ($urandom_range(0, 99) < black_pct);
            send_pix(p, 1'b0);
        end
        for (int i = 0; i <= w; i++)
        begin
            p.chan_zero = 8'($urandom_range(0, 255));
            p.chan_one = 8'($urandom_range(0, 255));
            p.chan_two = 8'($urandom_range(0, 255));
            p.drain = !($urandom_range(0, 99) < noise_pct);
            send_pix(p, i == w);
        end
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        items_sent = 0;
        stall_mode = 0;
        stall_cycle = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: undersized width and height saturate to 3, reset kernel (1.0 on the middle-row right tap)
        write_reg(c3e_pkg::REG_WIDTH, 64'd0);
        write_reg(c3e_pkg::REG_HEIGHT, 64'd2);
        run_frame(20, 30);

        // Directed: extreme weights and most negative offset
        write_reg(c3e_pkg::REG_W_TOP, 64'h8000_7FFF_0100);
        write_reg(c3e_pkg::REG_W_MID, 64'hFFFF_0200_8000);
        write_reg(c3e_pkg::REG_W_BOT, 64'h7FFF_0000_FF00);
        write_reg(c3e_pkg::REG_OFFSET, 64'h1_0000);
        write_reg(c3e_pkg::REG_WIDTH, 64'd4);
        write_reg(c3e_pkg::REG_HEIGHT, 64'd3);
        run_frame(10, 50);

        // Largest offset, oversized width and the top height, both later replaced
        write_reg(c3e_pkg::REG_OFFSET, 64'h0_FFFF);
        write_reg(c3e_pkg::REG_HEIGHT, 64'hFFFF);
        write_reg(c3e_pkg::REG_WIDTH, 64'd2047);
        write_reg(c3e_pkg::REG_HEIGHT, 64'd3);
        write_reg(c3e_pkg::REG_WIDTH, 64'd6);
        write_reg(c3e_pkg::REG_W_TOP, 64'h0040_0040_0040);
        write_reg(c3e_pkg::REG_W_MID, 64'h0040_0000_0040);
        write_reg(c3e_pkg::REG_W_BOT, 64'hFFC0_FFC0_FFC0);
        write_reg(c3e_pkg::REG_OFFSET, 64'h0_0800);
        run_frame(2, 5);

        // Random sizes and kernels, small frames only
        while (items_sent < 1100)
        begin
            bit wild;
            wild = ($urandom_range(0, 3) == 0);
            write_reg(c3e_pkg::REG_W_TOP, rand_kernel_row(wild));
            write_reg(c3e_pkg::REG_W_MID, rand_kernel_row(wild));
            write_reg(c3e_pkg::REG_W_BOT, rand_kernel_row(wild));
            write_reg(c3e_pkg::REG_OFFSET, 64'($urandom_range(0, 17'h1FFFF)));
            write_reg(c3e_pkg::REG_WIDTH, 64'($urandom_range(0, 4) == 0 ?
                                              $urandom_range(0, 2) :
                                              $urandom_range(3, 14)));
            write_reg(c3e_pkg::REG_HEIGHT, 64'($urandom_range(0, 4) == 0 ?
                                               $urandom_range(0, 2) :
                                               $urandom_range(3, 8)));
            run_frame($urandom_range(0, 10), $urandom_range(0, 20));
        end

        pix_valid <= 1'b0;
        wait_idle();
        $display("Sent %0d transfers over %0d frames; checked %0d filtered pixels",
                 items_sent, sb.frames_done, sb.results_seen);
        $display("Mismatches or unexpected results: %0d", sb.mismatches);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
